### design/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; used by every module of the block.
`default_nettype none

package sfr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;
  // Largest result burst one input word can cause.
  localparam int JOB_BYTES   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = $clog2(JOB_BYTES);

  localparam logic [1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [1:0] REG_PATTERN_BYTES = 2'd1;
  localparam logic [1:0] REG_REPLACE_LEN   = 2'd2;
  localparam logic [1:0] REG_REPLACE_BYTES = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_len;
    logic [63:0]      pattern_bytes;
    logic [LEN_W-1:0] replace_len;
    logic [63:0]      replace_bytes;
  } cfg_t;

  // One emit job: cnt bytes of data, then end of text if last.
  typedef struct packed {
    logic [JOB_BYTES*8-1:0] data;
    logic [CNT_W-1:0]       cnt;
    logic                   last;
  } job_t;

endpackage

`default_nettype wire

### design/sfr_front.sv
// Front end: holds the partial match and turns each input word into an emit job.
// Depends on sfr_pkg.
`default_nettype none

module sfr_front #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sfr_pkg::cfg_t cfg,
  input  wire logic          pat_clr,
  input  wire sfr_pkg::in_t  item,
  input  wire logic          take,
  output sfr_pkg::job_t      job
);

  localparam int CW = sfr_pkg::CNT_W;

  logic [7:0]    held [PATTERN_MAX];
  logic [7:0]    held_next [PATTERN_MAX];
  logic [CW-1:0] held_count;
  logic [CW-1:0] held_count_next;

  logic [7:0]    buf_b [PATTERN_MAX];
  logic [7:0]    pat [PATTERN_MAX];
  logic [CW-1:0] plen, rlen, h, n, s;
  logic          full, ok;

  always_comb begin
    plen = (cfg.pattern_len > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : cfg.pattern_len;
    rlen = (cfg.replace_len > CW'(REPLACE_MAX)) ? CW'(REPLACE_MAX) : cfg.replace_len;
    h = (plen == '0 || held_count >= plen) ? '0 : held_count;
    n = h + CW'(1);

    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat[i]   = cfg.pattern_bytes[8*i +: 8];
      buf_b[i] = (CW'(i) < h) ? held[i] : item.in_byte;
    end

    // whole pattern matched
    full = (n == plen);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (CW'(i) < n && buf_b[i] != pat[i]) full = 1'b0;
    end

    // shortest emitted lead such that the tail is again a proper prefix
    s  = n;
    ok = 1'b0;
    for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
      ok = (CW'(k) < n) && ((n - CW'(k)) < plen);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (k + j < PATTERN_MAX) begin
          if (CW'(k + j) < n && buf_b[k + j] != pat[j]) ok = 1'b0;
        end
      end
      if (ok) s = CW'(k);
    end

    for (int i = 0; i < PATTERN_MAX; i++) begin
      held_next[i] = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (CW'(k) == s + CW'(i)) held_next[i] = buf_b[k];
      end
    end

    job      = '0;
    job.last = item.in_last;
    if (plen == '0) begin
      job.data[7:0]   = item.in_byte;
      job.cnt         = CW'(1);
      held_count_next = '0;
    end else if (full) begin
      job.data        = cfg.replace_bytes;
      job.cnt         = rlen;
      held_count_next = '0;
    end else begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        job.data[8*i +: 8] = buf_b[i];
      end
      // last word flushes everything still held
      job.cnt         = item.in_last ? n : s;
      held_count_next = item.in_last ? '0 : (n - s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (pat_clr) begin
      held_count <= '0;
    end else if (take) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

### design/sfr_queue.sv
// Short job queue between front end and back end.
// Depends on sfr_pkg.
`default_nettype none

module sfr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sfr_pkg::job_t push_job,
  input  wire logic          pop,
  output sfr_pkg::job_t      head,
  output logic               head_valid,
  output logic               full
);

  localparam int DEPTH = sfr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfr_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/sfr_back.sv
// Back end: plays out the queue head one result word per cycle into an output register, unless out_ready stalls it.
// Depends on sfr_pkg.
`default_nettype none

module sfr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sfr_pkg::job_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sfr_pkg::out_t      out_data
);

  localparam int CW = sfr_pkg::CNT_W;
  localparam int IW = sfr_pkg::IDX_W;

  logic [IW-1:0] idx;
  logic          adv, emit, fin;
  sfr_pkg::out_t res;

  always_comb begin
    adv  = !out_valid || out_ready;
    pop  = 1'b0;
    emit = 1'b0;
    fin  = 1'b0;
    res  = '0;
    if (head_valid) begin
      if (head.cnt == '0 && !head.last) begin
        // nothing to say for this word
        pop = 1'b1;
      end else if (adv) begin
        emit = 1'b1;
        if (head.cnt == '0) begin
          res.out_last = 1'b1;
          fin          = 1'b1;
        end else begin
          res.out_byte   = head.data[{idx, 3'b000} +: 8];
          res.byte_valid = 1'b1;
          fin            = (CW'(idx) + CW'(1) == head.cnt);
          res.out_last   = head.last && fin;
        end
        pop = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (adv) out_valid <= emit;
      if (emit) idx <= fin ? '0 : idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= res;
  end

endmodule

`default_nettype wire

### design/stream_find_replace.sv
// Streaming find-and-replace over a byte stream, top level.
// Path: pattern compare and shift search (combinational), job queue, output register.
// Throughput: one input word per cycle while each causes at most one result and the
//   output is not stalled; a word with more than one result holds the back end until all
//   are out, and input stalls once the two-entry job queue is full.
// Reset (rst, synchronous): control registers clear to zero, held match and queue empty.
`default_nettype none

module stream_find_replace #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // input words
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sfr_pkg::in_t  in_data,
  // result words
  output logic               out_valid,
  input  wire logic          out_ready,
  output sfr_pkg::out_t      out_data,
  // register writes
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::job_t new_job, head;
  logic          pat_clr, take, q_full, head_valid, pop;

  // Register file. The user must write only while idle, to avoid a hazard with jobs in flight; not enforced here.
  assign cfg_ready = 1'b1;
  // Any pattern change drops the partial match.
  assign pat_clr = cfg_valid && (cfg_index == sfr_pkg::REG_PATTERN_LEN ||
                                 cfg_index == sfr_pkg::REG_PATTERN_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfr_pkg::REG_PATTERN_LEN:   cfg.pattern_len   <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_PATTERN_BYTES: cfg.pattern_bytes <= cfg_data;
        sfr_pkg::REG_REPLACE_LEN:   cfg.replace_len   <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACE_BYTES: cfg.replace_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front accepts whenever the queue has room; each word becomes exactly one job.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  sfr_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pat_clr (pat_clr),
    .item    (in_data),
    .take    (take),
    .job     (new_job)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_job   (new_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // Back drains jobs into the output register, stalling on out_ready only.
  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

### design/sfr_checker.sv
// Port-level checks for stream_find_replace, attached by bind.
// Depends on sfr_pkg and the top level's ports.
`default_nettype none

module sfr_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire sfr_pkg::out_t out_data,
  input wire logic          cfg_ready
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a word without a byte is only ever the end marker
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.out_last && out_data.out_byte == 8'd0)
    else $error("empty result word is not a clean end marker");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> cfg_ready)
    else $error("register port not ready");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
